### hdl/sbss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbss_pkg
// Shared types, register indexes and constants of the stereo biquad sine
// saturator.
// ----------------------------------------------------------------------------
package sbss_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_RIGHT = 3'd5;

  localparam logic [31:0] NOISE_RESET = 32'd16387;
  localparam logic [31:0] NOISE_BIAS  = 32'h7fff_ffff;
  localparam logic [63:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'h0001,
    ST_START = 14'h0002,
    ST_MAC   = 14'h0004,
    ST_FEND  = 14'h0008,
    ST_ANGLE = 14'h0010,
    ST_SDIV  = 14'h0020,
    ST_ROM0  = 14'h0040,
    ST_ROM1  = 14'h0080,
    ST_ROM2  = 14'h0100,
    ST_IMUL  = 14'h0200,
    ST_PLOAD = 14'h0400,
    ST_IDIV  = 14'h0800,
    ST_FIN   = 14'h1000,
    ST_OUT   = 14'h2000
  } sbss_state_e;

  // restoring long division, one quotient bit per loop pass
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series sine in q30, evaluated when the table is built
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] d;
    x2 = (x * x) >> 30;
    r  = 64'd1 << 30;
    for (int n = 7; n >= 1; n--) begin
      d = 64'((2 * n) * (2 * n + 1));
      r = (64'd1 << 30) - udiv64((x2 * r) >> 30, d);
    end
    return (x * r) >> 30;
  endfunction

endpackage
`default_nettype wire

### hdl/stereo_biquad_sine_saturator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_biquad_sine_saturator
// Serial biquad lowpass, sine soft clip and xorshift dither for one stereo
// sample pair per item, both channels on one shift-add multiplier and one
// restoring divider.
// Each item is processed serially, left channel then right, with the filter
//   on or in bypass; the serial multiplier (one coefficient bit per cycle)
//   and the restoring divider set the processing time.
// Flow: one item at a time, no new item until the last one is done; the output
//   register lets the next item in while a result waits.
// Reset: asynchronous, clears history, control and config registers; noise to 16387; datapath registers are not reset.
// ----------------------------------------------------------------------------
module stereo_biquad_sine_saturator #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int COEF_WIDTH      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        s_axis_tvalid_i,
  output      logic                                        s_axis_tready_o,
  // left_in, right_in
  input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         s_axis_tdata_i,
  // frame_end
  input  wire logic                                        s_axis_tlast_i,
  output      logic                                        m_axis_tvalid_o,
  input  wire logic                                        m_axis_tready_i,
  // left_out, right_out
  output      logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         m_axis_tdata_o,
  // frame_end_out
  output      logic                                        m_axis_tlast_o,
  input  wire logic                                        cfg_we_i,
  input  wire logic [sbss_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  wire logic [((COEF_WIDTH > 32) ? COEF_WIDTH : 32)-1:0] cfg_wdata_i
);
  import sbss_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COEF_WIDTH;
  localparam int TB    = SINE_TABLE_BITS;
  localparam int SFRAC = SW - 3;
  localparam int CFRAC = CW - 3;
  localparam int HP_W  = SW - 2;
  localparam int TAB_N = 1 << TB;
  localparam int QI    = TB + 1;
  localparam int QF    = 31 - TB;
  localparam int QMAX  = (QI > QF) ? QI : QF;
  localparam int RW    = HP_W + 1 + QMAX;
  localparam int ACC_W = SW + (((CW + 4) > 33) ? (CW + 4) : 33);
  localparam int MP_W  = (CW > HP_W) ? CW : HP_W;
  localparam int MAXS  = (MP_W > QMAX) ? MP_W : QMAX;
  localparam int CNT_W = $clog2(MAXS + 1);
  localparam int DW    = ((2 * SW + 7) / 8) * 8;

  localparam logic [63:0] HP_FULL =
    (PI_HALF_Q62 + (64'd1 << (61 - SFRAC))) >> (62 - SFRAC);
  localparam logic [HP_W-1:0]         HALF_PI  = HP_W'(HP_FULL);
  localparam logic signed [SW-1:0]    HP_S     = SW'(HALF_PI);
  localparam logic [TB:0]             TAB_LAST = (TB + 1)'(TAB_N);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (CFRAC - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX    = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN    = -Y_MAX - ACC_W'(1);
  localparam logic signed [33:0]      RND_C    = 34'(1) << (29 - SFRAC);
  localparam logic signed [33:0]      ONE_S    = 34'(1) << SFRAC;

  typedef logic [30:0] rom_t [TAB_N+1];

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] step;
    logic [63:0] a;
    step = PI_HALF_Q62 >> TB;
    for (int k = 0; k <= TAB_N; k++) begin
      a    = (64'(k) * step + (64'd1 << 31)) >> 32;
      t[k] = 31'(sin_q30(a));
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  sbss_state_e state_q, state_d;
  logic        ch_q, ch_d;
  logic [1:0]  term_q, term_d;
  logic        out_valid_q, out_valid_d;

  logic signed [CW-1:0] coef_b0_q, coef_a1_q, coef_a2_q;
  logic                 filt_on_q;
  logic signed [SW-1:0] x1_q [2];
  logic signed [SW-1:0] x2_q [2];
  logic signed [SW-1:0] y1_q [2];
  logic signed [SW-1:0] y2_q [2];
  logic [31:0]          noise_q [2];

  logic signed [SW-1:0]    xl_q, xl_d, xr_q, xr_d;
  logic                    last_q, last_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [MP_W-1:0]         mplier_q, mplier_d;
  logic                    msgn_q, msgn_d, sub_q, sub_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SW-1:0]    y_q, y_d;
  logic                    neg_q, neg_d, pneg_q, pneg_d;
  logic [RW-1:0]           div_q, div_d;
  logic [HP_W-1:0]         fr_q, fr_d;
  logic [TB:0]             rom_addr_q, rom_addr_d;
  logic [30:0]             rom_q, t0_q, t0_d;
  logic [SW-1:0]           res_l_q, res_l_d, res_r_q, res_r_d;
  logic [SW-1:0]           out_l_q, out_l_d, out_r_q, out_r_d;
  logic                    out_last_q, out_last_d;

  logic signed [SW-1:0]    xc, x1c, x2c, y1c, y2c;
  logic signed [SW+1:0]    sum_x;
  logic                    mlast, mneg;
  logic signed [ACC_W-1:0] acc_step, acc_sum, acc_rnd, y_sat;
  logic [RW-1:0]           div_sh, div_step;
  logic [HP_W:0]           div_top;
  logic [SW-1:0]           y_abs;
  logic [HP_W-1:0]         m_ang;
  logic signed [31:0]      rom_diff;
  logic [ACC_W-1:0]        p_abs;
  logic [QF-1:0]           q_lo;
  logic                    rem_nz;
  logic [33:0]             fd_mag;
  logic signed [33:0]      fd, smag, sv, ndev, nsh, tot, rnd_t;
  logic [31:0]             nz, n1, n2, n3;
  logic [SW-1:0]           fin_res;
  logic [31:0]             seed;

  assign xc  = ch_q ? xr_q : xl_q;
  assign x1c = x1_q[ch_q];
  assign x2c = x2_q[ch_q];
  assign y1c = y1_q[ch_q];
  assign y2c = y2_q[ch_q];
  assign sum_x = (SW + 2)'(xc) + ((SW + 2)'(x1c) <<< 1) + (SW + 2)'(x2c);

  // shift-add multiplier, one multiplier bit a cycle
  assign mlast    = (cnt_q == CNT_W'(1));
  assign mneg     = sub_q ^ (msgn_q & mlast);
  assign acc_step = !mplier_q[0] ? acc_q : (mneg ? acc_q - mcand_q : acc_q + mcand_q);

  // restoring divider by pi/2, one quotient bit a cycle
  assign div_sh   = {div_q[RW-2:0], 1'b0};
  assign div_top  = div_sh[RW-1:QMAX];
  assign div_step = (div_top >= {1'b0, HALF_PI}) ?
                    {div_top - {1'b0, HALF_PI}, div_sh[QMAX-1:1], 1'b1} : div_sh;

  assign acc_sum = acc_q + ACC_HALF;
  assign acc_rnd = acc_sum >>> CFRAC;
  always_comb begin
    if (acc_rnd > Y_MAX) begin
      y_sat = Y_MAX;
    end else if (acc_rnd < Y_MIN) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = acc_rnd;
    end
  end

  assign y_abs    = y_q[SW-1] ? SW'(-y_q) : SW'(y_q);
  assign m_ang    = (y_q > HP_S || y_q < -HP_S) ? HALF_PI : y_abs[HP_W-1:0];
  assign rom_diff = $signed({1'b0, rom_q}) - $signed({1'b0, t0_q});
  assign p_abs    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  // interpolation, sign, dither, final rounding and clamp
  assign q_lo   = div_q[QF-1:0];
  assign rem_nz = |div_q[RW-1:QMAX];
  assign fd_mag = 34'(q_lo) + 34'(pneg_q & rem_nz);
  assign fd     = pneg_q ? -$signed(fd_mag) : $signed(fd_mag);
  assign smag   = $signed(34'(t0_q)) + fd;
  assign sv     = neg_q ? -smag : smag;
  assign nz     = noise_q[ch_q];
  assign n1     = nz ^ (nz << 13);
  assign n2     = n1 ^ (n1 >> 17);
  assign n3     = n2 ^ (n2 << 5);
  assign ndev   = $signed(34'(n3)) - $signed(34'(NOISE_BIAS));
  assign nsh    = ndev >>> (SFRAC + 1);
  assign tot    = sv + nsh;
  assign rnd_t  = (tot + RND_C) >>> (30 - SFRAC);
  always_comb begin
    if (rnd_t > ONE_S) begin
      fin_res = SW'(ONE_S);
    end else if (rnd_t < -ONE_S) begin
      fin_res = SW'(-ONE_S);
    end else begin
      fin_res = SW'(rnd_t);
    end
  end

  assign seed = (cfg_wdata_i[31:0] == 32'd0) ? NOISE_RESET : cfg_wdata_i[31:0];

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    term_d      = term_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    xl_d        = xl_q;
    xr_d        = xr_q;
    last_d      = last_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    msgn_d      = msgn_q;
    sub_d       = sub_q;
    cnt_d       = cnt_q;
    y_d         = y_q;
    neg_d       = neg_q;
    pneg_d      = pneg_q;
    div_d       = div_q;
    fr_d        = fr_q;
    rom_addr_d  = rom_addr_q;
    t0_d        = t0_q;
    res_l_d     = res_l_q;
    res_r_d     = res_r_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          xl_d    = s_axis_tdata_i[SW-1:0];
          xr_d    = s_axis_tdata_i[2*SW-1:SW];
          last_d  = s_axis_tlast_i;
          ch_d    = 1'b0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (filt_on_q) begin
          acc_d    = '0;
          mcand_d  = ACC_W'(sum_x);
          mplier_d = MP_W'(coef_b0_q);
          msgn_d   = 1'b1;
          sub_d    = 1'b0;
          cnt_d    = CNT_W'(CW);
          term_d   = 2'd0;
          state_d  = ST_MAC;
        end else begin
          y_d     = xc;
          state_d = ST_ANGLE;
        end
      end
      ST_MAC: begin
        acc_d    = acc_step;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - CNT_W'(1);
        if (mlast) begin
          case (term_q)
            2'd0: begin
              mcand_d  = ACC_W'(y1c);
              mplier_d = MP_W'(coef_a1_q);
              sub_d    = 1'b1;
              cnt_d    = CNT_W'(CW);
              term_d   = 2'd1;
            end
            2'd1: begin
              mcand_d  = ACC_W'(y2c);
              mplier_d = MP_W'(coef_a2_q);
              sub_d    = 1'b1;
              cnt_d    = CNT_W'(CW);
              term_d   = 2'd2;
            end
            default: state_d = ST_FEND;
          endcase
        end
      end
      ST_FEND: begin
        y_d     = SW'(y_sat);
        state_d = ST_ANGLE;
      end
      ST_ANGLE: begin
        neg_d   = y_q[SW-1];
        div_d   = RW'(m_ang) << (QMAX - 1);
        cnt_d   = CNT_W'(QI);
        state_d = ST_SDIV;
      end
      ST_SDIV: begin
        div_d = div_step;
        cnt_d = cnt_q - CNT_W'(1);
        if (mlast) begin
          rom_addr_d = div_step[QI-1:0];
          fr_d       = div_step[QMAX +: HP_W];
          state_d    = ST_ROM0;
        end
      end
      ST_ROM0: begin
        rom_addr_d = (rom_addr_q == TAB_LAST) ? rom_addr_q : rom_addr_q + (TB + 1)'(1);
        state_d    = ST_ROM1;
      end
      ST_ROM1: begin
        t0_d    = rom_q;
        state_d = ST_ROM2;
      end
      ST_ROM2: begin
        acc_d    = '0;
        mcand_d  = ACC_W'(rom_diff);
        mplier_d = MP_W'(fr_q);
        msgn_d   = 1'b0;
        sub_d    = 1'b0;
        cnt_d    = CNT_W'(HP_W);
        state_d  = ST_IMUL;
      end
      ST_IMUL: begin
        acc_d    = acc_step;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - CNT_W'(1);
        if (mlast) begin
          state_d = ST_PLOAD;
        end
      end
      ST_PLOAD: begin
        pneg_d  = acc_q[ACC_W-1];
        div_d   = RW'(p_abs) << (QMAX - QF);
        cnt_d   = CNT_W'(QF);
        state_d = ST_IDIV;
      end
      ST_IDIV: begin
        div_d = div_step;
        cnt_d = cnt_q - CNT_W'(1);
        if (mlast) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ch_q) begin
          res_l_d = fin_res;
          ch_d    = 1'b1;
          state_d = ST_START;
        end else begin
          res_r_d = fin_res;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_l_d     = res_l_q;
          out_r_d     = res_r_q;
          out_last_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      term_q      <= 2'd0;
      out_valid_q <= 1'b0;
      coef_b0_q   <= '0;
      coef_a1_q   <= '0;
      coef_a2_q   <= '0;
      filt_on_q   <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        x1_q[i]    <= '0;
        x2_q[i]    <= '0;
        y1_q[i]    <= '0;
        y2_q[i]    <= '0;
        noise_q[i] <= NOISE_RESET;
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_FEND) begin
        x2_q[ch_q] <= x1c;
        x1_q[ch_q] <= xc;
        y2_q[ch_q] <= y1c;
        y1_q[ch_q] <= SW'(y_sat);
      end
      if (state_q == ST_FIN) begin
        noise_q[ch_q] <= n3;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COEF_B0:    coef_b0_q  <= CW'(cfg_wdata_i);
          CFG_COEF_A1:    coef_a1_q  <= CW'(cfg_wdata_i);
          CFG_COEF_A2:    coef_a2_q  <= CW'(cfg_wdata_i);
          CFG_FILTER_ON:  filt_on_q  <= cfg_wdata_i[0];
          CFG_SEED_LEFT:  noise_q[0] <= seed;
          CFG_SEED_RIGHT: noise_q[1] <= seed;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    xl_q       <= xl_d;
    xr_q       <= xr_d;
    last_q     <= last_d;
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    msgn_q     <= msgn_d;
    sub_q      <= sub_d;
    cnt_q      <= cnt_d;
    y_q        <= y_d;
    neg_q      <= neg_d;
    pneg_q     <= pneg_d;
    div_q      <= div_d;
    fr_q       <= fr_d;
    rom_addr_q <= rom_addr_d;
    rom_q      <= SINE_ROM[rom_addr_q];
    t0_q       <= t0_d;
    res_l_q    <= res_l_d;
    res_r_q    <= res_r_d;
    out_l_q    <= out_l_d;
    out_r_q    <= out_r_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DW'({out_r_q, out_l_q});
  assign m_axis_tlast_o  = out_last_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> state_q == ST_START)
    else $error("accepted item did not start the left channel");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC || state_q == ST_IMUL || state_q == ST_SDIV ||
     state_q == ST_IDIV) |-> cnt_q != '0)
    else $error("serial unit running with an empty step count");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("output valid raised outside the output state");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(out_l_q) <= $signed(SW'(ONE_S)) &&
                     $signed(out_l_q) >= -$signed(SW'(ONE_S))))
    else $error("left output beyond full scale");

endmodule
`default_nettype wire

### dv/stereo_biquad_sine_saturator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_biquad_sine_saturator_test
// Drives stereo sample items through the biquad sine saturator under several
// register settings and handshake pressure, predicts each filtered, clipped
// and dithered pair in fixed point and checks the output stream item by item.
// ----------------------------------------------------------------------------
module stereo_biquad_sine_saturator_test;
  import sbss_pkg::*;

  localparam int SW = 24;
  localparam int TAB_N = 1024;
  localparam int DRAIN_WAIT = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [SW-1:0] left;
    logic [SW-1:0] right;
    logic          fend;
  } pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  stereo_biquad_sine_saturator u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint unsigned sine_rom [0:TAB_N];
  longint          half_pi;
  longint          gain_b0, fb_a1, fb_a2;
  logic            filt_en;
  longint          hist [2][4];
  logic [31:0]     dither [2];

  pair_t pending_pairs [$];
  pair_t expected_pairs [$];
  int    sender_idle_pct, receiver_stall_pct;
  int    n_errors, n_in, n_out, n_settings, idle_cnt;

  function automatic longint unsigned taylor_sine(longint unsigned x);
    longint unsigned x2, r;
    x2 = (x * x) >> 30;
    r  = 64'd1 << 30;
    for (int n = 7; n >= 1; n--)
      r = (64'd1 << 30) - (((x2 * r) >> 30) / longint'((2 * n) * (2 * n + 1)));
    return (x * r) >> 30;
  endfunction

  function automatic longint floor_div(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic longint sine_of(longint a);
    longint unsigned m, num, idx, fr;
    longint t0, t1, s;
    m   = (a < 0) ? -a : a;
    num = m << 10;
    idx = num / half_pi;
    fr  = num % half_pi;
    if (idx >= TAB_N) begin
      idx = TAB_N;
      fr  = 0;
    end
    t0 = sine_rom[idx];
    t1 = (idx < TAB_N) ? sine_rom[idx + 1] : t0;
    s  = t0 + floor_div((t1 - t0) * longint'(fr), half_pi);
    return (a < 0) ? -s : s;
  endfunction

  function automatic logic [SW-1:0] saturate_channel(int ch, longint x);
    longint acc, y, s, o;
    if (filt_en) begin
      acc = gain_b0 * x + 2 * (gain_b0 * hist[ch][0]) + gain_b0 * hist[ch][1]
            - fb_a1 * hist[ch][2] - fb_a2 * hist[ch][3];
      y = (acc + (64'sd1 <<< 28)) >>> 29;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      hist[ch][1] = hist[ch][0];
      hist[ch][0] = x;
      hist[ch][3] = hist[ch][2];
      hist[ch][2] = y;
    end else begin
      y = x;
    end
    if (y > half_pi) y = half_pi;
    if (y < -half_pi) y = -half_pi;
    s = sine_of(y);
    dither[ch] ^= dither[ch] << 13;
    dither[ch] ^= dither[ch] >> 17;
    dither[ch] ^= dither[ch] << 5;
    s += (longint'({32'd0, dither[ch]}) - longint'(NOISE_BIAS)) >>> 22;
    o = (s + 256) >>> 9;
    if (o > 2097152) o = 2097152;
    if (o < -2097152) o = -2097152;
    return o[SW-1:0];
  endfunction

  function automatic pair_t predict_pair(pair_t p);
    pair_t r;
    r.left  = saturate_channel(0, longint'(signed'(p.left)));
    r.right = saturate_channel(1, longint'(signed'(p.right)));
    r.fend  = p.fend;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_pairs.push_back(predict_pair({s_axis_tdata_i[23:0],
                                               s_axis_tdata_i[47:24], s_axis_tlast_i}));
        n_in++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          pair_t p;
          p = pending_pairs.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {p.right, p.left};
          s_axis_tlast_i  <= p.fend;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_out++;
        if (expected_pairs.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected item %h last %b", $time, m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          pair_t e;
          e = expected_pairs.pop_front();
          if (m_axis_tdata_o[23:0] !== e.left) begin
            n_errors++;
            $display("%0t: left expected %h actual %h", $time, e.left, m_axis_tdata_o[23:0]);
          end
          if (m_axis_tdata_o[47:24] !== e.right) begin
            n_errors++;
            $display("%0t: right expected %h actual %h", $time, e.right,
                     m_axis_tdata_o[47:24]);
          end
          if (m_axis_tlast_o !== e.fend) begin
            n_errors++;
            $display("%0t: last expected %b actual %b", $time, e.fend, m_axis_tlast_o);
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i)
      idle_cnt = 0;
    else
      idle_cnt++;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress, %0d items outstanding", $time, expected_pairs.size());
      $display("[stereo_biquad_sine_saturator] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    logic [31:0] seed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    seed = (val == 0) ? NOISE_RESET : val;
    case (idx)
      CFG_COEF_B0:    gain_b0 = longint'(signed'(val));
      CFG_COEF_A1:    fb_a1 = longint'(signed'(val));
      CFG_COEF_A2:    fb_a2 = longint'(signed'(val));
      CFG_FILTER_ON:  filt_en = val[0];
      CFG_SEED_LEFT:  dither[0] = seed;
      CFG_SEED_RIGHT: dither[1] = seed;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(logic [31:0] b0, logic [31:0] a1, logic [31:0] a2, logic fon,
                       logic [31:0] sl, logic [31:0] sr);
    write_reg(CFG_COEF_B0, b0);
    write_reg(CFG_COEF_A1, a1);
    write_reg(CFG_COEF_A2, a2);
    write_reg(CFG_FILTER_ON, {31'd0, fon});
    write_reg(CFG_SEED_LEFT, sl);
    write_reg(CFG_SEED_RIGHT, sr);
    n_settings++;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || s_axis_tvalid_i || expected_pairs.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(3))
      0: return SW'($urandom());
      1: return SW'($signed($urandom_range(2097152 * 2)) - 2097152);
      2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
      default: return SW'($signed($urandom_range(65536)) - 32768);
    endcase
  endfunction

  task automatic push_pair(logic [SW-1:0] l, logic [SW-1:0] r, logic f);
    pair_t p;
    p.left = l;
    p.right = r;
    p.fend = f;
    pending_pairs.push_back(p);
  endtask

  initial begin
    int mode;
    int pcts [4][2] = '{'{0, 0}, '{47, 0}, '{0, 47}, '{31, 31}};
    for (int k = 0; k <= TAB_N; k++)
      sine_rom[k] = taylor_sine(((longint'(k) * (PI_HALF_Q62 >> 10)) + (64'd1 << 31)) >> 32);
    half_pi = (PI_HALF_Q62 + (64'd1 << 40)) >> 41;
    gain_b0 = 0; fb_a1 = 0; fb_a2 = 0; filt_en = 1'b0;
    for (int c = 0; c < 2; c++) begin
      dither[c] = NOISE_RESET;
      for (int j = 0; j < 4; j++) hist[c][j] = 0;
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults, bypass extremes
    push_pair(24'h7fffff, 24'h800000, 1'b0);
    push_pair(24'h000000, 24'hffffff, 1'b1);
    push_pair(24'h323f6a, 24'hcdc096, 1'b0);
    push_pair(24'h200000, 24'he00000, 1'b1);
    drain();
    // zero seeds, stray register indexes
    write_reg(CFG_SEED_LEFT, 32'd0);
    write_reg(CFG_SEED_RIGHT, 32'd0);
    write_reg(3'd6, 32'hffffffff);
    write_reg(3'd7, 32'hffffffff);
    push_pair(24'h555555, 24'haaaaaa, 1'b1);
    push_pair(24'h100000, 24'hf00000, 1'b0);
    drain();
    // filter overflow with extreme coefficients
    setup(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1, 32'hffffffff, 32'd1);
    for (int i = 0; i < 6; i++) push_pair(24'h7fffff, 24'h800000, i[0]);
    drain();
    setup(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1, 32'h80000000, 32'h12345678);
    for (int i = 0; i < 6; i++) push_pair(i[0] ? 24'h7fffff : 24'h800000, 24'h000001, 1'b1);
    drain();

    for (int seg = 0; seg < 16; seg++) begin
      mode = seg % 4;
      case ($urandom_range(3))
        0: setup(32'd6000000 + $urandom_range(2000000), -32'sd860000000 - $urandom_range(20000000),
                 32'd350000000 + $urandom_range(20000000), 1'b1, $urandom(), $urandom());
        1: setup($urandom(), $urandom(), $urandom(), 1'b1, $urandom(), $urandom());
        2: setup($urandom_range(536870912), -$urandom_range(536870912), $urandom_range(268435456),
                 1'b1, $urandom(), $urandom());
        default: setup($urandom(), $urandom(), $urandom(), 1'b0, $urandom(), $urandom());
      endcase
      sender_idle_pct = pcts[mode][0];
      receiver_stall_pct = pcts[mode][1];
      for (int i = 0; i < 88; i++)
        push_pair(rand_sample(), rand_sample(), $urandom_range(1));
      drain();
    end
    // back to register reset values
    setup(32'd0, 32'd0, 32'd0, 1'b0, NOISE_RESET, NOISE_RESET);
    for (int i = 0; i < 20; i++) push_pair(rand_sample(), rand_sample(), $urandom_range(1));
    drain();

    $display("covered %0d items in, %0d out over %0d register settings", n_in, n_out,
             n_settings);
    $display("bypass and filter, coefficient extremes, zero seeds, four idle patterns");
    if (n_errors == 0 && expected_pairs.size() == 0)
      $display("[stereo_biquad_sine_saturator] OK");
    else
      $display("[stereo_biquad_sine_saturator] ERROR");
    $finish;
  end

endmodule

### sim.f
hdl/sbss_pkg.sv
hdl/stereo_biquad_sine_saturator.sv
dv/stereo_biquad_sine_saturator_test.sv
